// ----- rtl/sfwd_pkg.sv -----
package sfwd_pkg;

   localparam int BYTE_W   = 8;
   localparam int TICK_W   = 16;
   localparam int POS_W    = 3;
   localparam int MAG_W    = 23;
   localparam int WEIGHT_W = 24;
   localparam int RECIP_W  = 24;
   localparam int PROD_W   = MAG_W + RECIP_W;
   localparam int DIV_SHIFT = 27;

   localparam logic              CMD_BYTE      = 1'b0;
   localparam logic              CMD_TICK      = 1'b1;
   localparam logic [POS_W-1:0]  POS_START     = 3'd0;
   localparam logic [POS_W-1:0]  POS_LAST_BYTE = 3'd4;
   localparam logic [POS_W-1:0]  POS_DONE      = 3'd5;
   localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd60;

   // ceil(2^27 / 10): exact quotient for any 23-bit magnitude
   localparam logic [RECIP_W-1:0] DIV10_RECIP = 24'hCCCCCD;

   typedef struct packed {
      logic             done;
      logic             tenths;
      logic             neg;
      logic [MAG_W-1:0] mag;
   } frame_type;

endpackage

// ----- rtl/sfwd_parser.sv -----
module sfwd_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [sfwd_pkg::BYTE_W-1:0]  req_tdata,
   input  logic                         req_tuser,
   input  logic                         csr_valid,
   input  logic [sfwd_pkg::TICK_W-1:0]  csr_data,
   output logic                         frame_valid,
   input  logic                         frame_ready,
   output sfwd_pkg::frame_type          frame
);

   logic [sfwd_pkg::TICK_W-1:0] timeout_ff;
   logic [sfwd_pkg::TICK_W-1:0] ticks_ff, ticks_in;
   logic [sfwd_pkg::POS_W-1:0]  pos_ff, pos_in, pos_eff;
   logic [sfwd_pkg::BYTE_W-1:0] bytes_ff [4];
   logic                        frame_valid_ff, frame_valid_in;
   sfwd_pkg::frame_type         frame_ff, frame_in;
   logic                        accept, is_byte, store_byte, finish;

   assign req_tready = !frame_valid_ff || frame_ready;
   assign accept     = req_tvalid && req_tready;
   assign is_byte    = accept && (req_tuser == sfwd_pkg::CMD_BYTE);

   assign pos_eff    = (ticks_ff > timeout_ff) ? sfwd_pkg::POS_START : pos_ff;
   assign store_byte = is_byte && (pos_eff < sfwd_pkg::POS_LAST_BYTE);
   assign finish     = is_byte && (pos_eff == sfwd_pkg::POS_LAST_BYTE);

   always_comb begin
      ticks_in = ticks_ff;
      pos_in   = pos_ff;
      if (accept) begin
         if (req_tuser == sfwd_pkg::CMD_TICK) begin
            if (ticks_ff != sfwd_pkg::TICK_MAX) begin
               ticks_in = ticks_ff + 1'b1;
            end
         end else begin
            ticks_in = '0;
            if (store_byte) begin
               pos_in = pos_eff + 1'b1;
            end else begin
               pos_in = sfwd_pkg::POS_DONE;
            end
         end
      end
   end

   always_comb begin
      frame_valid_in = frame_valid_ff;
      if (frame_ready) begin
         frame_valid_in = 1'b0;
      end
      if (finish) begin
         frame_valid_in = 1'b1;
      end
      frame_in.done   = bytes_ff[0][7];
      frame_in.tenths = (bytes_ff[1] != '0);
      frame_in.neg    = req_tdata[7];
      frame_in.mag    = {req_tdata[6:0], bytes_ff[3], bytes_ff[2]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff     <= sfwd_pkg::TIMEOUT_RESET;
         ticks_ff       <= '0;
         pos_ff         <= sfwd_pkg::POS_START;
         frame_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            timeout_ff <= csr_data;
         end
         ticks_ff       <= ticks_in;
         pos_ff         <= pos_in;
         frame_valid_ff <= frame_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_byte) begin
         bytes_ff[pos_eff[1:0]] <= req_tdata;
      end
      if (finish) begin
         frame_ff <= frame_in;
      end
   end

   assign frame_valid = frame_valid_ff;
   assign frame       = frame_ff;

endmodule

// ----- rtl/sfwd_scale.sv -----
module sfwd_scale (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           frame_valid,
   output logic                           frame_ready,
   input  sfwd_pkg::frame_type            frame,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sfwd_pkg::WEIGHT_W-1:0]  rsp_tdata,
   output logic                           rsp_tuser
);

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [sfwd_pkg::WEIGHT_W-1:0]       weight_ff, weight_in;
   logic                                done_ff;
   logic [sfwd_pkg::PROD_W-1:0]         prod;
   logic [sfwd_pkg::MAG_W-1:0]          quot, mag_sel;
   logic                                advance;

   assign advance     = !rsp_valid_ff || rsp_tready;
   assign frame_ready = advance;

   always_comb begin
      prod    = sfwd_pkg::PROD_W'(frame.mag) * sfwd_pkg::PROD_W'(sfwd_pkg::DIV10_RECIP);
      quot    = sfwd_pkg::MAG_W'(prod >> sfwd_pkg::DIV_SHIFT);
      mag_sel = frame.tenths ? quot : frame.mag;
      if (frame.neg) begin
         weight_in = '0 - sfwd_pkg::WEIGHT_W'(mag_sel);
      end else begin
         weight_in = sfwd_pkg::WEIGHT_W'(mag_sel);
      end
      rsp_valid_in = advance ? frame_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && frame_valid) begin
         weight_ff <= weight_in;
         done_ff   <= frame.done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = weight_ff;
   assign rsp_tuser  = done_ff;

endmodule

// ----- rtl/scale_frame_weight_decoder.sv -----
// A frame's fifth byte is registered in the parser, then in the output register, as its response.
// Throughput: one request per cycle unless the output stalls; the parser stage and the
// output register advance together, and the divide by ten is a single reciprocal multiply.
// Reset: synchronous, active high; clears frame position, tick count and valids,
// and sets the gap timeout to 60 ticks.
module scale_frame_weight_decoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [sfwd_pkg::BYTE_W-1:0]    req_tdata,   // [7:0] rx_byte
   input  logic                           req_tuser,   // [0] command
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sfwd_pkg::WEIGHT_W-1:0]  rsp_tdata,   // [23:0] weight
   output logic                           rsp_tuser,   // [0] weighing_done
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sfwd_pkg::TICK_W-1:0]    csr_data
);

   logic                frame_valid;
   logic                frame_ready;
   sfwd_pkg::frame_type frame;

   assign csr_ready = 1'b1;

   sfwd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .frame_valid (frame_valid),
      .frame_ready (frame_ready),
      .frame       (frame)
   );

   sfwd_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (frame_valid),
      .frame_ready (frame_ready),
      .frame       (frame),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

// ----- tb/sv/scale_frame_weight_decoder_tb.sv -----
module scale_frame_weight_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 4;

   typedef struct packed {
      logic signed [sfwd_pkg::WEIGHT_W-1:0] weight;
      logic                                 done;
   } weighing_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                         kind;
      logic                                 cmd;
      logic [sfwd_pkg::TICK_W-1:0]          value;
      logic                                 typed;
      logic signed [sfwd_pkg::WEIGHT_W-1:0] exp_weight;
      logic                                 exp_done;
   } directed_row_type;

   localparam int N_ROWS = 26;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [sfwd_pkg::BYTE_W-1:0]   req_tdata = '0;
   logic                          req_tuser = sfwd_pkg::CMD_BYTE;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [sfwd_pkg::WEIGHT_W-1:0] rsp_tdata;
   logic                          rsp_tuser;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [sfwd_pkg::TICK_W-1:0]   csr_data = '0;

   // predictor state
   logic [sfwd_pkg::TICK_W-1:0]   gap_limit;
   logic [sfwd_pkg::POS_W-1:0]    frame_pos;
   logic [sfwd_pkg::BYTE_W-1:0]   frame_buf [4];
   logic [sfwd_pkg::TICK_W-1:0]   silence_ticks;

   weighing_type        pending_weighings [$];
   int                  error_count = 0;
   int                  cycle_count = 0;
   int                  snd_idle_pct = 0;
   int                  rcv_idle_pct = 0;

   // timeout starts at 60 after reset; zero timeout is written mid-table
   directed_row_type directed_rows [N_ROWS] = '{
      '{ROW_REQ, sfwd_pkg::CMD_BYTE, 16'h0080, 1'b0, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_BYTE, 16'h0000, 1'b0, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_BYTE, 16'h00FF, 1'b0, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_BYTE, 16'h00FF, 1'b0, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_BYTE, 16'h007F, 1'b1, 24'sd8388607, 1'b1},
      '{ROW_REQ, sfwd_pkg::CMD_BYTE, 16'h0055, 1'b0, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_TICK, 16'h00A5, 1'b0, 24'sd0,       1'b0},
      '{ROW_CSR, sfwd_pkg::CMD_BYTE, 16'h0000, 1'b0, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_TICK, 16'h0000, 1'b0, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_BYTE, 16'h0000, 1'b0, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_BYTE, 16'h0001, 1'b0, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_BYTE, 16'h00FF, 1'b0, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_BYTE, 16'h00FF, 1'b0, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_BYTE, 16'h00FF, 1'b0, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_TICK, 16'h00FF, 1'b0, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_BYTE, 16'h007F, 1'b0, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_BYTE, 16'h0000, 1'b0, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_BYTE, 16'h0000, 1'b0, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_BYTE, 16'h0000, 1'b0, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_BYTE, 16'h0080, 1'b1, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_TICK, 16'h0000, 1'b0, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_BYTE, 16'h00FF, 1'b0, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_BYTE, 16'h000A, 1'b0, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_BYTE, 16'h0009, 1'b0, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_BYTE, 16'h0000, 1'b0, 24'sd0,       1'b0},
      '{ROW_REQ, sfwd_pkg::CMD_BYTE, 16'h0000, 1'b1, 24'sd0,       1'b1}
   };

   scale_frame_weight_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      weighing_type exp_w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_weighings.size() == 0) begin
            $display("%0t: unexpected response weight=%0d done=%0b", $time,
                     $signed(rsp_tdata), rsp_tuser);
            error_count++;
         end else begin
            exp_w = pending_weighings.pop_front();
            if ($signed(rsp_tdata) !== exp_w.weight) begin
               $display("%0t: weight expected %0d actual %0d", $time,
                        exp_w.weight, $signed(rsp_tdata));
               error_count++;
            end
            if (rsp_tuser !== exp_w.done) begin
               $display("%0t: weighing_done expected %0b actual %0b", $time,
                        exp_w.done, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   function automatic bit decode_weighing(input logic cmd,
                                          input logic [sfwd_pkg::BYTE_W-1:0] b,
                                          output weighing_type res);
      logic [sfwd_pkg::MAG_W-1:0] mag;
      res = '0;
      if (cmd == sfwd_pkg::CMD_TICK) begin
         if (silence_ticks != sfwd_pkg::TICK_MAX)
            silence_ticks = silence_ticks + 1'b1;
         return 1'b0;
      end
      if (silence_ticks > gap_limit)
         frame_pos = sfwd_pkg::POS_START;
      silence_ticks = '0;
      if (frame_pos >= sfwd_pkg::POS_DONE)
         return 1'b0;
      if (frame_pos < sfwd_pkg::POS_LAST_BYTE) begin
         frame_buf[frame_pos[1:0]] = b;
         frame_pos = frame_pos + 1'b1;
         return 1'b0;
      end
      frame_pos = sfwd_pkg::POS_DONE;
      mag = {b[6:0], frame_buf[3], frame_buf[2]};
      if (frame_buf[1] != '0)
         mag = sfwd_pkg::MAG_W'(mag / 10);
      res.weight = b[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      res.done   = frame_buf[0][7];
      return 1'b1;
   endfunction

   task automatic send_request(input logic cmd, input logic [sfwd_pkg::BYTE_W-1:0] b,
                               input logic typed, input weighing_type typed_res);
      weighing_type res;
      @(negedge clock);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      if (decode_weighing(cmd, b, res))
         pending_weighings.push_back(typed ? typed_res : res);
   endtask

   task automatic send_ticks(input int n);
      for (int i = 0; i < n; i++)
         send_request(sfwd_pkg::CMD_TICK, sfwd_pkg::BYTE_W'($urandom), 1'b0, '0);
   endtask

   task automatic send_bytes(input int n);
      for (int i = 0; i < n; i++)
         send_request(sfwd_pkg::CMD_BYTE, sfwd_pkg::BYTE_W'($urandom), 1'b0, '0);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_weighings.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_gap_timeout(input logic [sfwd_pkg::TICK_W-1:0] v);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      gap_limit = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly whole frames after a real gap; some short gaps, extra and missing bytes
   task automatic send_frame_burst();
      int                          gap;
      int                          nbytes;
      int                          r;
      logic [sfwd_pkg::BYTE_W-1:0] b;
      r = $urandom_range(0, 9);
      gap = (r < 7) ? int'(gap_limit) + 1 + $urandom_range(0, 2)
                    : $urandom_range(0, int'(gap_limit));
      send_ticks(gap);
      r = $urandom_range(0, 19);
      nbytes = (r < 14) ? 5 : (r < 17) ? $urandom_range(6, 8) : $urandom_range(1, 4);
      for (int i = 0; i < nbytes; i++) begin
         if (i > 0 && $urandom_range(0, 4) == 0)
            send_ticks($urandom_range(0, int'(gap_limit) + 1));
         b = sfwd_pkg::BYTE_W'($urandom);
         if (i == 1 && $urandom_range(0, 1) == 0)
            b = '0;
         send_request(sfwd_pkg::CMD_BYTE, b, 1'b0, '0);
      end
   endtask

   initial begin
      weighing_type typed_res;
      gap_limit     = sfwd_pkg::TIMEOUT_RESET;
      frame_pos     = sfwd_pkg::POS_START;
      silence_ticks = '0;
      for (int i = 0; i < 4; i++)
         frame_buf[i] = '0;

      snd_idle_pct = 36;
      rcv_idle_pct = 88;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_ROWS; i++) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            write_gap_timeout(directed_rows[i].value);
         end else begin
            typed_res.weight = directed_rows[i].exp_weight;
            typed_res.done   = directed_rows[i].exp_done;
            send_request(directed_rows[i].cmd,
                         directed_rows[i].value[sfwd_pkg::BYTE_W-1:0],
                         directed_rows[i].typed, typed_res);
         end
      end

      write_gap_timeout(16'd2);
      repeat (15) send_frame_burst();

      snd_idle_pct = 88;
      rcv_idle_pct = 36;
      write_gap_timeout(sfwd_pkg::TIMEOUT_RESET);
      repeat (2) send_frame_burst();

      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      write_gap_timeout(16'd1);
      repeat (20) send_frame_burst();

      // maximum timeout: short silences never end a frame
      send_ticks(2);
      send_bytes(2);
      write_gap_timeout(sfwd_pkg::TICK_MAX);
      send_ticks(40);
      send_bytes(6);

      wait_drained();
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
